### rtl/pbs_pkg.sv
// shared types, constants and helpers for the piece block scoreboard
// no dependencies; imported by pbs_block_store and piece_block_scoreboard
package pbs_pkg;

    // geometry of the tracked piece (block size is a power of two)
    localparam int MAX_BLOCKS = 64;
    localparam int BLOCK_SIZE = 16384;
    localparam int BLK_SHIFT  = $clog2(BLOCK_SIZE);
    localparam int BLK_AW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // field widths
    localparam int PLEN_W  = 21;
    localparam int PNUM_W  = 32;
    localparam int OFF_W   = 20;
    localparam int LEN_W   = 15;
    localparam int TOTAL_W = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(262144);

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_SAVE    = 2'd1,
        OP_RESET   = 2'd2,
        OP_QUERY   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_MISSING  = 2'd1,
        ST_NOT_FOUND   = 2'd2,
        ST_NOT_PENDING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BLK_MISSING   = 2'd0,
        BLK_PENDING   = 2'd1,
        BLK_RETRIEVED = 2'd2
    } t_blk_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIECE_LENGTH = 2'd0,
        REG_PIECE_NUMBER = 2'd1
    } t_cfg_reg;

    // request from the sequencer to the block state store
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [BLK_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BLK_AW-1:0] wr_addr;
        t_blk_state        wr_data;
    } t_store_req;

    // ceil(piece_length / BLOCK_SIZE), capped at MAX_BLOCKS
    function automatic logic [CNT_W-1:0] f_block_count(input logic [PLEN_W-1:0] plen);
        logic [PLEN_W:0] n;
        n = ((PLEN_W+1)'(plen) + (PLEN_W+1)'(BLOCK_SIZE - 1)) >> BLK_SHIFT;
        if (n > (PLEN_W+1)'(MAX_BLOCKS)) begin
            n = (PLEN_W+1)'(MAX_BLOCKS);
        end
        return CNT_W'(n);
    endfunction

endpackage

### rtl/piece_block_scoreboard.sv
// piece block scoreboard: sequencer, counters and result register
// one item at a time; a request goes through S_SCAN and a save with a good offset through S_SAVE_CHK
// (scan reads one block entry per cycle); a save with a bad offset, reset and query go straight to S_DONE;
// leaving S_DONE makes the result valid and the input ready again, held there while the output stalls
// synchronous active-low reset: piece length 262144, piece number 0, all blocks missing
// depends on pbs_pkg and pbs_block_store
module piece_block_scoreboard (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input requests
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [pbs_pkg::OFF_W-1:0]    i_block_offset,
    input  logic [pbs_pkg::LEN_W-1:0]    i_data_length,
    // results
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [pbs_pkg::OFF_W-1:0]    o_granted_offset,
    output logic [pbs_pkg::LEN_W-1:0]    o_granted_length,
    output logic [pbs_pkg::PNUM_W-1:0]   o_piece_echo,
    output logic                         o_all_retrieved,
    output logic                         o_any_pending,
    output logic [pbs_pkg::TOTAL_W-1:0]  o_bytes_done,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pbs_pkg::PNUM_W-1:0]   i_cfg_data
);
    import pbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_SCAN     = 4'b0010,
        S_SAVE_CHK = 4'b0100,
        S_DONE     = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [PLEN_W-1:0]     r_piece_len;
    logic [PNUM_W-1:0]     r_piece_num;
    logic [CNT_W-1:0]      r_blk_cnt;
    logic [CNT_W-1:0]      r_pend_cnt;
    logic [CNT_W-1:0]      r_done_cnt;
    logic [TOTAL_W-1:0]    r_total;
    logic [CNT_W-1:0]      r_rd_idx;
    logic                  r_chk_vld;
    logic [BLK_AW-1:0]     r_chk_idx;
    logic [BLK_AW-1:0]     r_sv_idx;
    logic [LEN_W-1:0]      r_sv_len;
    t_status               r_res_status;
    logic [OFF_W-1:0]      r_res_off;
    logic [LEN_W-1:0]      r_res_len;
    logic [PNUM_W-1:0]     r_res_piece;
    logic                  r_out_valid;

    t_store_req            store_req;
    t_blk_state            rd_data;
    logic                  in_fire;
    logic                  cfg_fire;
    logic                  cfg_new_piece;
    logic                  op_clear;
    t_opcode               op;
    logic [OFF_W-1:0]      sv_idx_wide;
    logic                  sv_ok;
    logic                  scan_issue;
    logic                  found;
    logic                  out_free;
    logic [31:0]           g_start;
    logic [31:0]           g_rest;
    logic [31:0]           g_len;
    logic [TOTAL_W:0]      sum;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire  = i_in_valid && o_in_ready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign cfg_new_piece = cfg_fire && (i_cfg_index == REG_PIECE_LENGTH);
    assign op = t_opcode'(i_opcode);
    assign op_clear = in_fire && (op == OP_RESET);
    assign out_free = !r_out_valid || i_out_ready;

    // save offset decode: exact block boundary below the block count
    assign sv_idx_wide = i_block_offset >> BLK_SHIFT;
    assign sv_ok = (i_block_offset[BLK_SHIFT-1:0] == '0) &&
                   (sv_idx_wide < OFF_W'(r_blk_cnt));

    // scan pipeline: one read issued per cycle, checked once the store's registered read port returns it
    assign scan_issue = (r_rd_idx < r_blk_cnt);
    assign found = r_chk_vld && (rd_data == BLK_MISSING);

    // grant geometry of the block under check
    assign g_start = 32'(r_chk_idx) << BLK_SHIFT;
    assign g_rest  = 32'(r_piece_len) - g_start;
    assign g_len   = (g_rest < 32'(BLOCK_SIZE)) ? g_rest : 32'(BLOCK_SIZE);

    // saturating byte count
    assign sum = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(r_sv_len);

    // store request mux
    always_comb begin
        store_req = '0;
        store_req.clear = cfg_new_piece || op_clear;
        if (r_state == S_SCAN) begin
            store_req.rd_en   = scan_issue && !found;
            store_req.rd_addr = r_rd_idx[BLK_AW-1:0];
            store_req.wr_en   = found;
            store_req.wr_addr = r_chk_idx;
            store_req.wr_data = BLK_PENDING;
        end else if (r_state == S_SAVE_CHK) begin
            store_req.wr_en   = (rd_data == BLK_PENDING);
            store_req.wr_addr = r_sv_idx;
            store_req.wr_data = BLK_RETRIEVED;
        end else if (in_fire && op == OP_SAVE) begin
            store_req.rd_en   = sv_ok;
            store_req.rd_addr = sv_idx_wide[BLK_AW-1:0];
        end
    end

    pbs_block_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (op)
                        OP_REQUEST: n_state = S_SCAN;
                        OP_SAVE:    n_state = sv_ok ? S_SAVE_CHK : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (found || (!scan_issue && !r_chk_vld)) begin
                    n_state = S_DONE;
                end
            end
            S_SAVE_CHK: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piece_len <= PLEN_RESET;
            r_blk_cnt   <= f_block_count(PLEN_RESET);
            r_piece_num <= '0;
        end else if (cfg_fire) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PIECE_LENGTH: begin
                    r_piece_len <= i_cfg_data[PLEN_W-1:0];
                    r_blk_cnt   <= f_block_count(i_cfg_data[PLEN_W-1:0]);
                end
                REG_PIECE_NUMBER: r_piece_num <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // block counters and byte total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_new_piece || op_clear) begin
            r_pend_cnt <= '0;
            r_done_cnt <= '0;
            r_total    <= '0;
        end else if (r_state == S_SCAN && found) begin
            r_pend_cnt <= r_pend_cnt + CNT_W'(1);
        end else if (r_state == S_SAVE_CHK && rd_data == BLK_PENDING) begin
            r_pend_cnt <= r_pend_cnt - CNT_W'(1);
            r_done_cnt <= r_done_cnt + CNT_W'(1);
            r_total    <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
    end

    // scan and save working registers, pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_chk_vld <= scan_issue && !found;
        end else begin
            r_chk_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_idx     <= '0;
            r_sv_idx     <= sv_idx_wide[BLK_AW-1:0];
            r_sv_len     <= i_data_length;
            r_res_off    <= '0;
            r_res_len    <= '0;
            r_res_piece  <= '0;
            case (op)
                OP_REQUEST: r_res_status <= ST_NO_MISSING;
                OP_SAVE:    r_res_status <= sv_ok ? ST_OK : ST_NOT_FOUND;
                default:    r_res_status <= ST_OK;
            endcase
        end else if (r_state == S_SCAN) begin
            if (scan_issue && !found) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            r_chk_idx <= r_rd_idx[BLK_AW-1:0];
            if (found) begin
                r_res_status <= ST_OK;
                r_res_off    <= g_start[OFF_W-1:0];
                r_res_len    <= g_len[LEN_W-1:0];
                r_res_piece  <= r_piece_num;
            end
        end else if (r_state == S_SAVE_CHK && rd_data != BLK_PENDING) begin
            r_res_status <= ST_NOT_PENDING;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_status         <= r_res_status;
            o_granted_offset <= r_res_off;
            o_granted_length <= r_res_len;
            o_piece_echo     <= r_res_piece;
            o_all_retrieved  <= (r_done_cnt == r_blk_cnt);
            o_any_pending    <= (r_pend_cnt != '0);
            o_bytes_done     <= r_total;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/pbs_block_store.sv
// block state store: one state entry per block with a registered read port
// valid bits make a cleared entry read as missing; depends on pbs_pkg
module pbs_block_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pbs_pkg::t_store_req   i_req,
    output pbs_pkg::t_blk_state   o_rd_data
);
    import pbs_pkg::*;

    logic [1:0]            r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_vld;
    logic [1:0]            r_q_mem;
    logic                  r_q_vld;

    // valid bits, cleared at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // state array write
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q_mem <= r_mem[i_req.rd_addr];
            r_q_vld <= r_vld[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_q_vld ? t_blk_state'(r_q_mem) : BLK_MISSING;

endmodule
